// ----- hdl/shpg_pkg.sv -----
// ----------------------------------------------------------------------------
// shpg_pkg : shared types, constants and tables of the halton generator
// Prime bases, reciprocals for the digit divider, digit counts per base and
// the flat table of radical inverse weights floor(2^32 / b^k).
// ----------------------------------------------------------------------------
package shpg_pkg;

  // item function codes
  localparam logic FUNC_WRITE    = 1'b0;
  localparam logic FUNC_GENERATE = 1'b1;

  // configuration register indexes
  localparam logic REG_NUM_DIMS = 1'b0;

  localparam int NUM_PRIMES    = 10;
  localparam int FRACTION_BITS = 32;
  localparam int RECIP_SHIFT   = 35;
  localparam int TOTAL_DIGITS  = 120;
  localparam int WIDX_W        = $clog2(TOTAL_DIGITS);

  localparam logic [35:0] DIV_ONE = 36'h8_0000_0000;

  localparam logic [4:0] PRIME [NUM_PRIMES] = '{
    5'd2, 5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19, 5'd23, 5'd29
  };

  // floor(2^35 / b), quotient estimate is exact or one short
  localparam logic [34:0] RECIP [NUM_PRIMES] = '{
    35'(DIV_ONE / 36'd2),  35'(DIV_ONE / 36'd3),  35'(DIV_ONE / 36'd5),
    35'(DIV_ONE / 36'd7),  35'(DIV_ONE / 36'd11), 35'(DIV_ONE / 36'd13),
    35'(DIV_ONE / 36'd17), 35'(DIV_ONE / 36'd19), 35'(DIV_ONE / 36'd23),
    35'(DIV_ONE / 36'd29)
  };

  // digit positions with a non-zero weight, largest k with b^k <= 2^32
  localparam logic [5:0] DIGITS_PER_BASE [NUM_PRIMES] = '{
    6'd32, 6'd20, 6'd13, 6'd11, 6'd9, 6'd8, 6'd7, 6'd7, 6'd7, 6'd6
  };

  // start of each base's run of weights in the flat table
  localparam logic [WIDX_W-1:0] WEIGHT_OFFSET [NUM_PRIMES] = '{
    7'd0, 7'd32, 7'd52, 7'd65, 7'd76, 7'd85, 7'd93, 7'd100, 7'd107, 7'd114
  };

  typedef logic [31:0] weight_tab_t [TOTAL_DIGITS];

  // request to the digit divider
  typedef struct packed {
    logic        start;
    logic [3:0]  dim;
    logic [31:0] dividend;
  } div_req_t;

  // answer of the digit divider
  typedef struct packed {
    logic        done;
    logic [4:0]  digit;
    logic [31:0] quotient;
  } div_rsp_t;

  // base of a dimension, zero for a dimension with no prime
  function automatic logic [4:0] prime_of(logic [3:0] d);
    logic [4:0] b;
    unique case (d)
      4'd0:    b = 5'd2;
      4'd1:    b = 5'd3;
      4'd2:    b = 5'd5;
      4'd3:    b = 5'd7;
      4'd4:    b = 5'd11;
      4'd5:    b = 5'd13;
      4'd6:    b = 5'd17;
      4'd7:    b = 5'd19;
      4'd8:    b = 5'd23;
      4'd9:    b = 5'd29;
      default: b = 5'd0;
    endcase
    return b;
  endfunction

  // weights by repeated floor division through the reciprocals
  function automatic weight_tab_t build_weights();
    weight_tab_t tab;
    logic [32:0] w;
    logic [67:0] prod;
    logic [32:0] q;
    logic [32:0] r;
    int          idx;
    tab = '{default: '0};
    idx = 0;
    for (int d = 0; d < NUM_PRIMES; d++) begin
      w = 33'd1 << FRACTION_BITS;
      for (int k = 0; k < int'(DIGITS_PER_BASE[d]); k++) begin
        prod = 68'(w) * 68'(RECIP[d]);
        q    = 33'(prod >> RECIP_SHIFT);
        r    = w - 33'(q * 33'(PRIME[d]));
        if (r >= 33'(PRIME[d])) begin
          q = q + 33'd1;
        end
        w = q;
        tab[idx] = 32'(w);
        idx = idx + 1;
      end
    end
    return tab;
  endfunction

  localparam weight_tab_t WEIGHT = build_weights();

endpackage

// ----- hdl/shpg_perm_mem.sv -----
// ----------------------------------------------------------------------------
// shpg_perm_mem : permutation store
// One write port and one registered read port over the digit permutations.
// ----------------------------------------------------------------------------
module shpg_perm_mem #(
  parameter int DEPTH = 10240,
  parameter int AW    = 14
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [4:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [4:0]    rd_data
);

  logic [4:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/shpg_digit_div.sv -----
// ----------------------------------------------------------------------------
// shpg_digit_div : divide by the dimension's prime base
// Two stages: reciprocal multiply, then remainder correction. Gives the
// low base-b digit and the quotient from the second stage register.
// ----------------------------------------------------------------------------
module shpg_digit_div (
  input  logic               clk,
  input  logic               rst,
  input  shpg_pkg::div_req_t req,
  output shpg_pkg::div_rsp_t rsp
);

  logic        s1_valid;
  logic [31:0] s1_q0;
  logic [31:0] s1_dividend;
  logic [4:0]  s1_base;

  logic [66:0] prod;
  logic [31:0] rem_full;
  logic [5:0]  rem;
  logic [5:0]  base_ext;

  // quotient estimate from the reciprocal
  assign prod = 67'(req.dividend) * 67'(shpg_pkg::RECIP[req.dim]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= req.start;
    end
    s1_q0       <= 32'(prod >> shpg_pkg::RECIP_SHIFT);
    s1_dividend <= req.dividend;
    s1_base     <= shpg_pkg::PRIME[req.dim];
  end

  // remainder lies below twice the base
  assign rem_full = s1_dividend - 32'(s1_q0 * 32'(s1_base));
  assign rem      = rem_full[5:0];
  assign base_ext = 6'(s1_base);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= s1_valid;
    end
    if (rem >= base_ext) begin
      rsp.digit    <= 5'(rem - base_ext);
      rsp.quotient <= s1_q0 + 32'd1;
    end else begin
      rsp.digit    <= rem[4:0];
      rsp.quotient <= s1_q0;
    end
  end

endmodule

// ----- hdl/scrambled_halton_point_generator_core.sv -----
// ----------------------------------------------------------------------------
// scrambled_halton_point_generator_core : scrambled halton point generator
// A write word is taken whenever the block is idle. A generate word registers each
// coordinate after walking min(K_b, MAX_DIGITS) digits through the shared digit
// divider, which takes a new digit request only after its previous answer, and the
// next word is taken once the last coordinate of the point is registered; a held result
// word adds its wait. Reset clears control, num_dims to 2; the store is not cleared.
// ----------------------------------------------------------------------------
module scrambled_halton_point_generator_core #(
  parameter int MAX_DIMS        = 10,
  parameter int MAX_DIGITS      = 32,
  parameter int SLOTS_PER_DIGIT = 32
) (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [3:0]  dimension_sel,
  input  logic [4:0]  digit_position,
  input  logic [4:0]  digit_value,
  input  logic [4:0]  permuted_value,
  input  logic [31:0] point_index,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] coordinate,
  output logic [3:0]  coord_dimension,
  output logic        last_coordinate,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = MAX_DIMS * MAX_DIGITS * SLOTS_PER_DIGIT;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]  state;
  logic [3:0]  num_dims;
  logic [3:0]  ndims;
  logic [3:0]  dims_clamped;
  logic [3:0]  dim;
  logic [4:0]  pos;
  logic [31:0] index_reg;

  logic        dig_v;
  logic [4:0]  dig;
  logic [4:0]  dig_pos;
  logic        rd_v;
  logic [31:0] rd_weight;
  logic [4:0]  rd_data;
  logic        term_v;
  logic [31:0] term;
  logic [31:0] acc;

  logic        gen_accept;
  logic        wr_accept;
  logic        wr_ok;
  logic [4:0]  wr_base;
  logic        out_free;
  logic        pipe_empty;
  logic        emit;
  logic        last_pos;
  logic        last_dim;
  logic [5:0]  digit_limit;
  logic [shpg_pkg::WIDX_W-1:0] widx;
  logic        cfg_write;

  shpg_pkg::div_req_t div_req;
  shpg_pkg::div_rsp_t div_rsp;

  // flat address of a permutation entry
  function automatic logic [AW-1:0] perm_addr(logic [3:0] d, logic [4:0] p,
                                              logic [4:0] s);
    return AW'((AW'(d) * AW'(MAX_DIGITS) + AW'(p)) * AW'(SLOTS_PER_DIGIT)
               + AW'(s));
  endfunction

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == shpg_pkg::REG_NUM_DIMS);
  assign prdata    = (paddr[2] == shpg_pkg::REG_NUM_DIMS) ? {28'd0, num_dims} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims <= 4'd2;
    end else if (cfg_write) begin
      num_dims <= pwdata[3:0];
    end
  end

  // dimension count held to its range
  always_comb begin
    if (num_dims == 4'd0) begin
      dims_clamped = 4'd1;
    end else if (num_dims > 4'(MAX_DIMS)) begin
      dims_clamped = 4'(MAX_DIMS);
    end else begin
      dims_clamped = num_dims;
    end
  end

  // handshake and control terms
  assign in_ready   = (state == ST_IDLE);
  assign gen_accept = in_valid && in_ready && (func == shpg_pkg::FUNC_GENERATE);
  assign wr_accept  = in_valid && in_ready && (func == shpg_pkg::FUNC_WRITE);
  assign out_free   = !out_valid || out_ready;
  assign pipe_empty = !dig_v && !rd_v && !term_v;
  assign emit       = (state == ST_DRAIN) && pipe_empty && out_free;
  assign last_dim   = (dim == ndims - 4'd1);

  assign digit_limit = (6'(MAX_DIGITS) < shpg_pkg::DIGITS_PER_BASE[dim]) ?
                       6'(MAX_DIGITS) : shpg_pkg::DIGITS_PER_BASE[dim];
  assign last_pos    = (pos == 5'(digit_limit - 6'd1));

  // permutation write checks
  assign wr_base = shpg_pkg::prime_of(dimension_sel);
  assign wr_ok   = (32'(dimension_sel) < 32'(MAX_DIMS))
                && (32'(digit_position) < 32'(MAX_DIGITS))
                && (digit_value < wr_base) && (permuted_value < wr_base)
                && (32'(digit_value) < 32'(SLOTS_PER_DIGIT));

  // divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dim      = dim;
    div_req.dividend = div_rsp.quotient;
    unique case (state)
      ST_IDLE: begin
        div_req.start    = gen_accept;
        div_req.dim      = 4'd0;
        div_req.dividend = point_index;
      end
      ST_RUN: begin
        div_req.start    = div_rsp.done && !last_pos;
        div_req.dim      = dim;
        div_req.dividend = div_rsp.quotient;
      end
      ST_DRAIN: begin
        div_req.start    = emit && !last_dim;
        div_req.dim      = dim + 4'd1;
        div_req.dividend = index_reg;
      end
      default: begin
        div_req.start    = 1'b0;
      end
    endcase
  end

  shpg_digit_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  shpg_perm_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_accept && wr_ok),
    .wr_addr (perm_addr(dimension_sel, digit_position, digit_value)),
    .wr_data (permuted_value),
    .rd_en   (dig_v),
    .rd_addr (perm_addr(dim, dig_pos, dig)),
    .rd_data (rd_data)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (gen_accept) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (div_rsp.done && last_pos) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (emit) begin
            state <= last_dim ? ST_IDLE : ST_RUN;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // point, dimension and position tracking
  always_ff @(posedge clk) begin
    if (gen_accept) begin
      index_reg <= point_index;
      ndims     <= dims_clamped;
      dim       <= 4'd0;
      pos       <= 5'd0;
    end else if (emit && !last_dim) begin
      dim <= dim + 4'd1;
      pos <= 5'd0;
    end else if ((state == ST_RUN) && div_rsp.done && !last_pos) begin
      pos <= pos + 5'd1;
    end
  end

  // digit pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      dig_v  <= 1'b0;
      rd_v   <= 1'b0;
      term_v <= 1'b0;
    end else begin
      dig_v  <= div_rsp.done;
      rd_v   <= dig_v;
      term_v <= rd_v;
    end
  end

  // digit capture, weight lookup, weighting and sum
  assign widx = shpg_pkg::WEIGHT_OFFSET[dim] + shpg_pkg::WIDX_W'(dig_pos);

  always_ff @(posedge clk) begin
    dig       <= div_rsp.digit;
    dig_pos   <= pos;
    rd_weight <= shpg_pkg::WEIGHT[widx];
    term      <= 32'(37'(rd_data) * 37'(rd_weight));
    if (div_req.start && (state != ST_RUN)) begin
      acc <= 32'd0;
    end else if (term_v) begin
      acc <= acc + term;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      coordinate      <= acc;
      coord_dimension <= dim;
      last_coordinate <= last_dim;
    end
  end

endmodule

// ----- tb/scrambled_halton_point_generator_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrambled_halton_point_generator_core_tb : halton generator testbench
// Loads shuffled permutations in full for the two lowest dimensions, and the
// slots that point indices zero and one reach in every other dimension. It then
// runs directed and random write and generate words over several dimension
// counts, with random idling on both handshakes and one long output hold.
// A scoreboard predicts every coordinate word and checks it in order.
// ----------------------------------------------------------------------------
module scrambled_halton_point_generator_core_tb;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 8;
  localparam int DIM_LIMIT     = 10;
  localparam int POS_LIMIT     = 32;
  localparam int SLOT_LIMIT    = 32;
  localparam int FULL_DIMS     = 2;
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD     = 700;
  localparam int LONG_HOLD_AT  = 10;
  localparam int RANDOM_WORDS  = 50;
  localparam int CALM_FROM     = 40;
  localparam logic [2:0] ADDR_NUM_DIMS = 3'(4 * shpg_pkg::REG_NUM_DIMS);
  localparam int unsigned BASE_OF [DIM_LIMIT] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29};
  localparam int unsigned DIGITS_OF [DIM_LIMIT] = '{32, 20, 13, 11, 9, 8, 7, 7, 7, 6};

  typedef struct {
    logic        func;
    logic [3:0]  dsel;
    logic [4:0]  pos;
    logic [4:0]  slot;
    logic [4:0]  val;
    logic [31:0] idx;
  } in_word_t;

  typedef struct {
    logic [31:0] coordinate;
    logic [3:0]  dim;
    logic        last;
  } coord_word_t;

  // permutation store, dimension count and the coordinates still to come
  class point_scoreboard;
    logic [4:0]  perm_store [DIM_LIMIT][POS_LIMIT][SLOT_LIMIT];
    logic [3:0]  num_dims;
    coord_word_t pending_coords [$];
    int          mismatches;
    int          checked;

    function new();
      num_dims   = 4'd2;
      mismatches = 0;
      checked    = 0;
      foreach (perm_store[d, p, s]) perm_store[d][p][s] = '0;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // zero acts as one, anything above the prime count as the prime count
    function int unsigned dims_in_use();
      if (num_dims == 0) return 1;
      if (num_dims > DIM_LIMIT) return DIM_LIMIT;
      return int'(num_dims);
    endfunction

    // permuted digits weighted by floor(2^32 / b^k), leading zeros included
    function logic [31:0] radical_sum(int unsigned d, logic [31:0] idx);
      logic [63:0] one;
      logic [63:0] power;
      logic [63:0] rest;
      logic [63:0] acc;
      int unsigned b;
      int unsigned k;
      int unsigned dig;
      b     = BASE_OF[d];
      one   = 64'd1 << 32;
      power = 64'(b);
      rest  = 64'(idx);
      acc   = '0;
      k     = 0;
      while (k < POS_LIMIT && power <= one) begin
        dig   = int'(rest % 64'(b));
        acc   = acc + 64'(perm_store[d][k][dig]) * (one / power);
        rest  = rest / 64'(b);
        power = power * 64'(b);
        k++;
      end
      return acc[31:0];
    endfunction

    // returns 1 when the word updates the store or asks for a point
    function bit note_word(in_word_t w);
      coord_word_t c;
      int unsigned n;
      if (w.func == shpg_pkg::FUNC_WRITE) begin
        if (w.dsel >= DIM_LIMIT) return 0;
        if (w.slot >= BASE_OF[w.dsel] || w.val >= BASE_OF[w.dsel]) return 0;
        perm_store[w.dsel][w.pos][w.slot] = w.val;
        return 1;
      end
      n = dims_in_use();
      for (int unsigned d = 0; d < n; d++) begin
        c.coordinate = radical_sum(d, w.idx);
        c.dim        = 4'(d);
        c.last       = (d + 1 == n);
        pending_coords.push_back(c);
      end
      return 1;
    endfunction

    task check_coord(logic [31:0] coord, logic [3:0] dim, logic last);
      coord_word_t e;
      if (pending_coords.size() == 0) begin
        report_mismatch($sformatf("unexpected word: coordinate %h dimension %0d", coord, dim));
        return;
      end
      e = pending_coords.pop_front();
      checked++;
      if (coord !== e.coordinate) begin
        report_mismatch($sformatf("dim %0d coordinate %h, expected %h",
                                  e.dim, coord, e.coordinate));
      end
      if (dim !== e.dim) begin
        report_mismatch($sformatf("coord_dimension %0d, expected %0d", dim, e.dim));
      end
      if (last !== e.last) begin
        report_mismatch($sformatf("dim %0d last_coordinate %b, expected %b",
                                  e.dim, last, e.last));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = shpg_pkg::FUNC_WRITE;
  logic [3:0]  dimension_sel = '0;
  logic [4:0]  digit_position = '0;
  logic [4:0]  digit_value = '0;
  logic [4:0]  permuted_value = '0;
  logic [31:0] point_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] coordinate;
  logic [3:0]  coord_dimension;
  logic        last_coordinate;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  point_scoreboard sb = new();
  bit          calm = 1'b0;
  int unsigned loaded = 0;
  int unsigned points = 0;
  int unsigned updates = 0;
  int unsigned ignored = 0;
  int unsigned settings = 0;

  scrambled_halton_point_generator_core dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .func            (func),
    .dimension_sel   (dimension_sel),
    .digit_position  (digit_position),
    .digit_value     (digit_value),
    .permuted_value  (permuted_value),
    .point_index     (point_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .coordinate      (coordinate),
    .coord_dimension (coord_dimension),
    .last_coordinate (last_coordinate),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic in_word_t make_word(logic f, int unsigned d, int unsigned p,
                                         int unsigned s, int unsigned v, logic [31:0] idx);
    in_word_t w;
    w.func = f;
    w.dsel = 4'(d);
    w.pos  = 5'(p);
    w.slot = 5'(s);
    w.val  = 5'(v);
    w.idx  = idx;
    return w;
  endfunction

  // mostly points and in-range writes, the rest raw noise
  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned pick;
    int unsigned d;
    w = make_word(shpg_pkg::FUNC_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      w.func = shpg_pkg::FUNC_GENERATE;
      case ($urandom_range(0, 3))
        0: w.idx = 32'($urandom_range(0, 63));
        1: w.idx = ~32'($urandom_range(0, 63));
        default: ;
      endcase
      // wider points stay on the slots loaded for indices zero and one
      if (sb.dims_in_use() > FULL_DIMS) w.idx = 32'($urandom_range(0, 1));
    end else if (pick < 85) begin
      d      = $urandom_range(0, DIM_LIMIT - 1);
      w.dsel = 4'(d);
      w.slot = 5'($urandom_range(0, BASE_OF[d] - 1));
      w.val  = 5'($urandom_range(0, BASE_OF[d] - 1));
    end
    return w;
  endfunction

  // offer one word and hold it until taken
  task automatic send_word(input in_word_t w, output bit took);
    func           <= w.func;
    dimension_sel  <= w.dsel;
    digit_position <= w.pos;
    digit_value    <= w.slot;
    permuted_value <= w.val;
    point_index    <= w.idx;
    in_valid       <= 1'b1;
    do @(posedge clk); while (!in_ready);
    took = sb.note_word(w);
    if (w.func == shpg_pkg::FUNC_GENERATE) points++;
    else if (took) updates++;
    else ignored++;
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // wait for every coordinate, then let the block go quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_coords.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup then access cycle on the configuration port
  task automatic write_num_dims(logic [3:0] nd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_NUM_DIMS;
    pwdata  <= 32'(nd);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.num_dims = nd;
    settings++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stimulus
  initial begin
    bit          took;
    int unsigned shuffle [SLOT_LIMIT];
    int unsigned j;
    int unsigned tmp;
    int unsigned b;
    int unsigned span;
    int unsigned counted;
    int unsigned phase_left;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // shuffled permutations: every slot of the low dimensions, else the slots
    // that indices zero and one reach
    for (int d = 0; d < DIM_LIMIT; d++) begin
      b = BASE_OF[d];
      for (int p = 0; p < DIGITS_OF[d]; p++) begin
        for (int s = 0; s < b; s++) shuffle[s] = s;
        for (int s = b - 1; s > 0; s--) begin
          j          = $urandom_range(0, s);
          tmp        = shuffle[s];
          shuffle[s] = shuffle[j];
          shuffle[j] = tmp;
        end
        if (d < FULL_DIMS) span = b;
        else if (p == 0) span = 2;
        else span = 1;
        for (int s = 0; s < span; s++) begin
          send_word(make_word(shpg_pkg::FUNC_WRITE, d, p, s, shuffle[s], $urandom), took);
          loaded++;
          if ($urandom_range(0, 15) == 0) sender_gap();
        end
      end
    end

    // directed: reset dimension count, index extremes, write corner cases
    send_word(make_word(shpg_pkg::FUNC_GENERATE, 0, 0, 0, 0, 32'h0000_0000), took);
    send_word(make_word(shpg_pkg::FUNC_GENERATE, 15, 31, 31, 31, 32'hFFFF_FFFF), took);
    send_word(make_word(shpg_pkg::FUNC_GENERATE, 0, 0, 0, 0, 32'h0000_0001), took);
    send_word(make_word(shpg_pkg::FUNC_WRITE, 0, 0, 1, 0, 32'h0), took);
    send_word(make_word(shpg_pkg::FUNC_GENERATE, 0, 0, 0, 0, 32'h0000_0001), took);
    // out of range dimension, slot or value, all ignored
    send_word(make_word(shpg_pkg::FUNC_WRITE, 15, 0, 0, 0, 32'h0), took);
    send_word(make_word(shpg_pkg::FUNC_WRITE, 10, 3, 1, 1, 32'h0), took);
    send_word(make_word(shpg_pkg::FUNC_WRITE, 0, 0, 2, 1, 32'h0), took);
    send_word(make_word(shpg_pkg::FUNC_WRITE, 1, 0, 0, 3, 32'h0), took);
    send_word(make_word(shpg_pkg::FUNC_WRITE, 9, 5, 31, 0, 32'h0), took);
    send_word(make_word(shpg_pkg::FUNC_WRITE, 0, 0, 0, 31, 32'h0), took);
    // top corner of the store and all-twos in base 3
    send_word(make_word(shpg_pkg::FUNC_WRITE, 9, 31, 28, 28, 32'h0), took);
    send_word(make_word(shpg_pkg::FUNC_WRITE, 1, 19, 2, 2, 32'h0), took);
    send_word(make_word(shpg_pkg::FUNC_GENERATE, 0, 0, 0, 0, 32'd3486784400), took);
    send_word(make_word(shpg_pkg::FUNC_GENERATE, 0, 0, 0, 0, 32'h8000_0000), took);
    drain();
    write_num_dims(4'd10);
    send_word(make_word(shpg_pkg::FUNC_GENERATE, 0, 0, 0, 0, 32'h0000_0001), took);
    send_word(make_word(shpg_pkg::FUNC_GENERATE, 0, 0, 0, 0, 32'h0000_0000), took);
    drain();
    write_num_dims(4'd0);
    send_word(make_word(shpg_pkg::FUNC_GENERATE, 0, 0, 0, 0, 32'd12345), took);
    drain();
    write_num_dims(4'd15);
    send_word(make_word(shpg_pkg::FUNC_GENERATE, 0, 0, 0, 0, 32'h0000_0001), took);
    drain();
    write_num_dims(4'd1);
    send_word(make_word(shpg_pkg::FUNC_GENERATE, 0, 0, 0, 0, 32'hAAAA_AAAA), took);

    // random phases, each under its own dimension count
    counted    = 0;
    phase_left = 0;
    while (counted < RANDOM_WORDS) begin
      if (phase_left == 0) begin
        drain();
        if ($urandom_range(0, 2) == 0) write_num_dims(4'd10);
        else write_num_dims(4'($urandom_range(0, 15)));
        phase_left = $urandom_range(8, 16);
      end
      send_word(random_word(), took);
      if (took) begin
        counted++;
        phase_left--;
      end
      if (counted >= CALM_FROM) calm = 1'b1;
      sender_gap();
    end

    drain();
    $display("summary: %0d table loads, %0d points, %0d store updates, %0d ignored writes",
             loaded, points, updates, ignored);
    $display("summary: %0d coordinate words checked over %0d dimension settings",
             sb.checked, settings);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // result side: random stalls and one long hold while words are offered
  initial begin
    int unsigned hold_left;
    bit          long_hold_done;
    hold_left      = 0;
    long_hold_done = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_coord(coordinate, coord_dimension, last_coordinate);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && sb.checked >= LONG_HOLD_AT && in_valid) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD - 1;
        out_ready     <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        hold_left  = $urandom_range(1, 9) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    #(64'd600_000 * CLK_PERIOD);
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/shpg_pkg.sv
hdl/shpg_perm_mem.sv
hdl/shpg_digit_div.sv
hdl/scrambled_halton_point_generator_core.sv
tb/scrambled_halton_point_generator_core_tb.sv
